FILE: hw/rtl/accel_step_detector_macros.svh
// assertion macros shared by the step detector rtl
`ifndef ACCEL_STEP_DETECTOR_MACROS_SVH
`define ACCEL_STEP_DETECTOR_MACROS_SVH

// condition holds at every edge outside reset
`define ASD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASD_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/asd_pkg.sv
// types, constants and codes of the acceleration step detector
package asd_pkg;

  // sample window geometry
  localparam int WINDOW_DEPTH = 100;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int REM_W        = $clog2(WINDOW_DEPTH);

  // floor(2^32 / depth), estimate of a quotient is low by at most one
  localparam logic [31:0] DEPTH_RECIP = 32'((64'd1 << 32) / 64'(WINDOW_DEPTH));

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM_MEAN_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_TICKS = 2'd2;

  // configuration reset values
  localparam logic [63:0] RST_SPREAD_THRESHOLD = 64'd1000000000000000;
  localparam logic [31:0] RST_REARM_MEAN_LIMIT = 32'd2800000000;
  localparam logic [15:0] RST_REFRACTORY_TICKS = 16'd500;

  // input transaction
  typedef struct packed {
    logic [31:0] accel_sample;
    logic [31:0] tick_time;
  } in_t;

  // result transaction
  typedef struct packed {
    logic        step_seen;
    logic [31:0] step_total;
    logic [31:0] window_mean;
    logic [63:0] window_spread;
    logic        armed;
  } out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_NEW,
    ST_SQ_OLD,
    ST_DIV_NEW,
    ST_DIV_OLD,
    ST_FIX_OLD,
    ST_MEAN,
    ST_MEAN_SQ,
    ST_SPREAD_A,
    ST_SPREAD_B,
    ST_DECIDE
  } asd_state_t;

endpackage

FILE: hw/rtl/asd_ram.sv
// generic simple dual port ram with registered read
module asd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/accel_step_detector.sv
// the result is registered once the sequencer has run ST_SQ_NEW to ST_DECIDE
// one transaction at a time, held off by in_stall, as the single shared
//   32x32 multiplier serves the sum of squares, mean and spread updates
// the window lives in a ram; entries not yet written since reset read as zero
// reset clears sums, slot and count, arms and loads config; no clearing pass
module accel_step_detector (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  asd_pkg::in_t                      in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output asd_pkg::out_t                     out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [asd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                       cfg_data
);
  import asd_pkg::*;

  `include "accel_step_detector_macros.svh"

  // control state
  asd_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic             wrapped_r, wrapped_nxt;
  logic [63:0]      s2_r, s2_nxt;
  logic [31:0]      mean_r, mean_nxt;
  logic [REM_W-1:0] rem_r, rem_nxt;
  logic [31:0]      prev_r, prev_nxt;
  logic             armed_r, armed_nxt;
  logic [31:0]      last_r, last_nxt;
  logic [31:0]      count_r, count_nxt;
  logic [63:0]      thr_r, thr_nxt;
  logic [31:0]      limit_r, limit_nxt;
  logic [15:0]      refr_r, refr_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload state
  logic [31:0]      sample_r, sample_nxt;
  logic [31:0]      tick_r, tick_nxt;
  logic [31:0]      old_r, old_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [31:0]      qn_r, qn_nxt;
  logic [REM_W-1:0] rn_r, rn_nxt;
  logic [31:0]      qo_r, qo_nxt;
  logic [REM_W-1:0] ro_r, ro_nxt;
  logic [63:0]      tmp_r, tmp_nxt;
  logic [63:0]      spread_r, spread_nxt;
  out_t             out_r, out_nxt;

  // ram signals
  logic             ram_we;
  logic [31:0]      ram_rdata;

  // shared multiplier
  logic [31:0]      mul_a, mul_b;

  // divide-by-depth correction unit
  logic [31:0]      div_val, div_q0, div_r0, div_q;
  logic [REM_W-1:0] div_r;

  // mean combination and decision
  logic signed [REM_W+1:0] rsum;
  logic [31:0]      qsum;
  logic             step_now;
  logic [31:0]      elapsed;
  logic             out_load;

  asd_ram #(
    .WIDTH (32),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // quotient estimate from the reciprocal product, fixed up by one compare
  always_comb begin
    div_val = (state_r == ST_DIV_OLD) ? sample_r : old_r;
    div_q0  = prod_r[63:32];
    div_r0  = div_val - 32'(64'(div_q0) * 64'(WINDOW_DEPTH));
    if (div_r0 >= 32'(WINDOW_DEPTH)) begin
      div_q = div_q0 + 32'd1;
      div_r = REM_W'(div_r0 - 32'(WINDOW_DEPTH));
    end else begin
      div_q = div_q0;
      div_r = REM_W'(div_r0);
    end
  end

  // running quotient and remainder of the window sum
  always_comb begin
    rsum = $signed({2'b00, rem_r}) + $signed({2'b00, rn_r}) - $signed({2'b00, ro_r});
    qsum = mean_r + qn_r - qo_r;
  end

  // step and re-arm decision
  assign step_now = armed_r && (sample_r > mean_r) && (prev_r < mean_r) &&
                    (spread_r > thr_r);
  assign elapsed  = tick_r - last_r;
  assign out_load = (state_r == ST_DECIDE) && (!out_valid_r || !out_stall);

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    wrapped_nxt   = wrapped_r;
    s2_nxt        = s2_r;
    mean_nxt      = mean_r;
    rem_nxt       = rem_r;
    prev_nxt      = prev_r;
    armed_nxt     = armed_r;
    last_nxt      = last_r;
    count_nxt     = count_r;
    thr_nxt       = thr_r;
    limit_nxt     = limit_r;
    refr_nxt      = refr_r;
    out_valid_nxt = out_valid_r;
    sample_nxt    = sample_r;
    tick_nxt      = tick_r;
    old_nxt       = old_r;
    qn_nxt        = qn_r;
    rn_nxt        = rn_r;
    qo_nxt        = qo_r;
    ro_nxt        = ro_r;
    tmp_nxt       = tmp_r;
    spread_nxt    = spread_r;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    mul_a         = sample_r;
    mul_b         = sample_r;

    // result register drains
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // configuration writes
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SPREAD_THRESHOLD: thr_nxt   = cfg_data;
        CFG_REARM_MEAN_LIMIT: limit_nxt = cfg_data[31:0];
        CFG_REFRACTORY_TICKS: refr_nxt  = cfg_data[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_data.accel_sample;
          tick_nxt   = in_data.tick_time;
          state_nxt  = ST_SQ_NEW;
        end
      end
      ST_SQ_NEW: begin
        // oldest entry out, new sample in
        old_nxt = wrapped_r ? ram_rdata : 32'd0;
        ram_we  = 1'b1;
        if (32'(slot_r) == 32'(WINDOW_DEPTH - 1)) begin
          slot_nxt    = '0;
          wrapped_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
        state_nxt = ST_SQ_OLD;
      end
      ST_SQ_OLD: begin
        s2_nxt    = s2_r + prod_r;
        mul_a     = old_r;
        mul_b     = old_r;
        state_nxt = ST_DIV_NEW;
      end
      ST_DIV_NEW: begin
        s2_nxt    = s2_r - prod_r;
        mul_b     = DEPTH_RECIP;
        state_nxt = ST_DIV_OLD;
      end
      ST_DIV_OLD: begin
        qn_nxt    = div_q;
        rn_nxt    = div_r;
        mul_a     = old_r;
        mul_b     = DEPTH_RECIP;
        state_nxt = ST_FIX_OLD;
      end
      ST_FIX_OLD: begin
        qo_nxt    = div_q;
        ro_nxt    = div_r;
        state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        // remainder back into zero to depth minus one
        if (rsum < 0) begin
          mean_nxt = qsum - 32'd1;
          rem_nxt  = REM_W'(rsum + (REM_W+2)'(WINDOW_DEPTH));
        end else if (rsum >= (REM_W+2)'(WINDOW_DEPTH)) begin
          mean_nxt = qsum + 32'd1;
          rem_nxt  = REM_W'(rsum - (REM_W+2)'(WINDOW_DEPTH));
        end else begin
          mean_nxt = qsum;
          rem_nxt  = REM_W'(rsum);
        end
        state_nxt = ST_MEAN_SQ;
      end
      ST_MEAN_SQ: begin
        mul_a     = mean_r;
        mul_b     = mean_r;
        state_nxt = ST_SPREAD_A;
      end
      ST_SPREAD_A: begin
        // spread = s2 - depth * mean^2 - 2 * rem * mean
        tmp_nxt   = s2_r - 64'(prod_r * 64'(WINDOW_DEPTH));
        mul_a     = 32'(rem_r);
        mul_b     = mean_r;
        state_nxt = ST_SPREAD_B;
      end
      ST_SPREAD_B: begin
        spread_nxt = tmp_r - {prod_r[62:0], 1'b0};
        state_nxt  = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (out_load) begin
          prev_nxt = sample_r;
          if (step_now) begin
            count_nxt = count_r + 32'd1;
            armed_nxt = 1'b0;
            last_nxt  = tick_r;
          end else if (!armed_r && (mean_r < limit_r) && (elapsed > {16'd0, refr_r})) begin
            armed_nxt = 1'b1;
          end
          out_nxt.step_seen     = step_now;
          out_nxt.step_total    = step_now ? count_r + 32'd1 : count_r;
          out_nxt.window_mean   = mean_r;
          out_nxt.window_spread = spread_r;
          out_nxt.armed         = step_now ? 1'b0 :
                                  (armed_r || ((mean_r < limit_r) &&
                                               (elapsed > {16'd0, refr_r})));
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    prod_nxt = 64'(mul_a) * 64'(mul_b);
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      wrapped_r   <= 1'b0;
      s2_r        <= '0;
      mean_r      <= '0;
      rem_r       <= '0;
      prev_r      <= '0;
      armed_r     <= 1'b1;
      last_r      <= '0;
      count_r     <= '0;
      thr_r       <= RST_SPREAD_THRESHOLD;
      limit_r     <= RST_REARM_MEAN_LIMIT;
      refr_r      <= RST_REFRACTORY_TICKS;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      wrapped_r   <= wrapped_nxt;
      s2_r        <= s2_nxt;
      mean_r      <= mean_nxt;
      rem_r       <= rem_nxt;
      prev_r      <= prev_nxt;
      armed_r     <= armed_nxt;
      last_r      <= last_nxt;
      count_r     <= count_nxt;
      thr_r       <= thr_nxt;
      limit_r     <= limit_nxt;
      refr_r      <= refr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
    tick_r   <= tick_nxt;
    old_r    <= old_nxt;
    prod_r   <= prod_nxt;
    qn_r     <= qn_nxt;
    rn_r     <= rn_nxt;
    qo_r     <= qo_nxt;
    ro_r     <= ro_nxt;
    tmp_r    <= tmp_nxt;
    spread_r <= spread_nxt;
    out_r    <= out_nxt;
  end

  // checks
  `ASD_ASSERT_ALWAYS(a_rem_range, 32'(rem_r) < 32'(WINDOW_DEPTH), "remainder out of range")
  `ASD_ASSERT_ALWAYS(a_slot_range, 32'(slot_r) < 32'(WINDOW_DEPTH), "write slot out of range")
  `ASD_ASSERT_IMPLIES(a_step_disarms, out_valid_r && out_r.step_seen, !out_r.armed, "step left detector armed")
  `ASD_ASSERT_NEXT(a_accept_starts, in_valid && !in_stall, state_r == ST_SQ_NEW, "accepted transaction not started")
  `ASD_ASSERT_NEXT(a_step_counts, out_load && step_now, count_r == $past(count_r) + 32'd1, "step not counted")

endmodule

FILE: tb/sv/accel_step_detector_test.sv
// self-checking testbench for the acceleration step detector: window mean, spread and step decisions
module accel_step_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import asd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;
  localparam int SETTLE_CYCLES       = 14;
  localparam int QUIET_LIMIT         = 5000;
  localparam int LONG_HOLD_CYCLES    = 300;
  localparam int LONG_HOLD_AFTER     = 150;
  localparam int REPORTED_MISMATCHES = 10;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_t                  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_t                 out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data  = '0;

  accel_step_detector i_dut (.*);

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // detector copy: window, step state and register values
  logic [31:0]  win_copy [WINDOW_DEPTH];
  int unsigned  next_slot;
  logic [31:0]  last_sample;
  logic         is_armed;
  logic [31:0]  step_tick;
  logic [31:0]  steps_so_far;
  logic [63:0]  spread_limit;
  logic [31:0]  mean_limit;
  logic [15:0]  refractory_len;

  // stimulus side view of the window, used to aim samples at the mean
  logic [31:0]  shadow_win [WINDOW_DEPTH];
  int unsigned  shadow_slot;
  logic [31:0]  tick_now;
  logic [31:0]  gait_level;
  logic [31:0]  gait_swing;
  logic         gait_high;
  int           gait_left;

  in_t          queued_samples [$];
  out_t         pending_reports [$];
  int unsigned  queued_count   = 0;
  int unsigned  accepted_count = 0;
  int unsigned  checked_count  = 0;
  int unsigned  error_count    = 0;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_idle_pct  = 0;
  int unsigned  hold_left      = 0;
  logic         long_hold_done = 1'b0;
  int unsigned  quiet_cycles   = 0;

  // one sample through the detector copy, returns the report it causes
  function automatic out_t detector_update(in_t item);
    out_t        res;
    logic [63:0] total;
    logic [63:0] spread;
    logic [63:0] dev;
    logic [31:0] mean;
    logic [31:0] elapsed;
    int          i;
    res = '0;
    win_copy[next_slot] = item.accel_sample;
    next_slot = (next_slot + 1) % WINDOW_DEPTH;
    total = '0;
    for (i = 0; i < WINDOW_DEPTH; i++) total += 64'(win_copy[i]);
    mean = 32'(total / 64'(WINDOW_DEPTH));
    spread = '0;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      dev = (win_copy[i] >= mean) ? 64'(win_copy[i] - mean) : 64'(mean - win_copy[i]);
      spread += dev * dev;
    end
    // step test comes first, re-arm test sees its outcome
    if (is_armed && item.accel_sample > mean && last_sample < mean && spread > spread_limit) begin
      steps_so_far += 32'd1;
      is_armed = 1'b0;
      step_tick = item.tick_time;
      res.step_seen = 1'b1;
    end
    elapsed = item.tick_time - step_tick;
    if (!is_armed && mean < mean_limit && elapsed > 32'(refractory_len)) is_armed = 1'b1;
    last_sample = item.accel_sample;
    res.step_total    = steps_so_far;
    res.window_mean   = mean;
    res.window_spread = spread;
    res.armed         = is_armed;
    return res;
  endfunction

  // queue one sample for the driver and track it in the shadow window
  function automatic void offer_sample(logic [31:0] value, logic [31:0] tick);
    in_t item;
    item.accel_sample = value;
    item.tick_time    = tick;
    queued_samples.push_back(item);
    queued_count++;
    shadow_win[shadow_slot] = value;
    shadow_slot = (shadow_slot + 1) % WINDOW_DEPTH;
  endfunction

  // sample that lands exactly on the mean of the window it joins
  function automatic logic [31:0] mean_matching_sample();
    logic [63:0] others;
    int          i;
    others = '0;
    for (i = 0; i < WINDOW_DEPTH; i++) begin
      if (i != shadow_slot) others += 64'(shadow_win[i]);
    end
    return 32'(others / 64'(WINDOW_DEPTH - 1));
  endfunction

  // mostly walking patterns around a level, with flat, random and extreme samples mixed in
  task automatic queue_random_samples(input int count);
    logic [63:0] value;
    logic [31:0] offset;
    int          kind;
    repeat (count) begin
      if (gait_left == 0) begin
        gait_level = $urandom() >> $urandom_range(6);
        gait_swing = $urandom() >> $urandom_range(12);
        gait_left  = $urandom_range(60, 20);
      end
      gait_left--;
      kind = $urandom_range(99);
      if (kind < 72) begin
        if ($urandom_range(2) == 0) gait_high = !gait_high;
        offset = $urandom_range(gait_swing);
        if (gait_high) begin
          value = 64'(gait_level) + 64'(offset);
          if (value > 64'hFFFF_FFFF) value = 64'hFFFF_FFFF;
        end else begin
          value = (offset > gait_level) ? 64'h0 : 64'(gait_level - offset);
        end
      end else if (kind < 80) begin
        value = 64'(mean_matching_sample());
      end else if (kind < 92) begin
        value = 64'($urandom());
      end else begin
        value = ($urandom_range(1) == 1) ? 64'hFFFF_FFFF : 64'h0;
      end
      // ticks mostly advance a little, sometimes around the refractory span, rarely jump
      kind = $urandom_range(99);
      if (kind < 88) tick_now += $urandom_range(150);
      else if (kind < 96) tick_now += $urandom_range(600, 400);
      else tick_now = $urandom();
      offer_sample(value[31:0], tick_now);
    end
  endtask

  // register write on the config channel, copy updated at the handshake
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SPREAD_THRESHOLD: spread_limit = value;
      CFG_REARM_MEAN_LIMIT: mean_limit = value[31:0];
      CFG_REFRACTORY_TICKS: refractory_len = value[15:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every queued sample is taken and every report checked
  task automatic drain();
    do @(posedge clk);
    while (accepted_count != queued_count || pending_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        pending_reports.push_back(detector_update(in_data));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        if (queued_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= queued_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result stall, with one long hold-off so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!long_hold_done && checked_count >= LONG_HOLD_AFTER) begin
      hold_left = LONG_HOLD_CYCLES;
      long_hold_done = 1'b1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (pending_reports.size() == 0) begin
        error_count++;
        if (error_count <= REPORTED_MISMATCHES)
          $display("tb: unexpected result transaction %p", out_data);
      end else begin
        want = pending_reports.pop_front();
        if (out_data.step_seen !== want.step_seen || out_data.step_total !== want.step_total ||
            out_data.window_mean !== want.window_mean ||
            out_data.window_spread !== want.window_spread || out_data.armed !== want.armed) begin
          error_count++;
          if (error_count <= REPORTED_MISMATCHES) begin
            $display("tb: result %0d expected seen=%0b total=%0d mean=%0d spread=%0d armed=%0b",
                     checked_count, want.step_seen, want.step_total, want.window_mean,
                     want.window_spread, want.armed);
            $display("tb: result %0d actual   seen=%0b total=%0d mean=%0d spread=%0d armed=%0b",
                     checked_count, out_data.step_seen, out_data.step_total,
                     out_data.window_mean, out_data.window_spread, out_data.armed);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // sequence of phases
  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      win_copy[i]   = '0;
      shadow_win[i] = '0;
    end
    next_slot      = 0;
    last_sample    = '0;
    is_armed       = 1'b1;
    step_tick      = '0;
    steps_so_far   = '0;
    spread_limit   = RST_SPREAD_THRESHOLD;
    mean_limit     = RST_REARM_MEAN_LIMIT;
    refractory_len = RST_REFRACTORY_TICKS;
    shadow_slot    = 0;
    tick_now       = 32'h0000_0500;
    gait_left      = 0;
    gait_high      = 1'b0;
    gait_level     = '0;
    gait_swing     = '0;
    send_idle_pct  = 20;
    recv_idle_pct  = 86;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed samples under reset register values
    offer_sample(32'h0000_0000, 32'h0000_0000);  // sample equal to an all-zero mean
    offer_sample(32'hFFFF_FFFF, 32'hFFFF_FF00);  // first step, tick near wrap
    offer_sample(32'h0000_0000, 32'hFFFF_FF80);
    offer_sample(32'hFFFF_FFFF, 32'h0000_00F4);  // elapsed equals refractory across wrap
    offer_sample(32'h0000_0000, 32'h0000_00F5);  // one tick more, re-arms
    offer_sample(32'hFFFF_FFFF, 32'h0000_0100);  // second step
    offer_sample(mean_matching_sample(), 32'h0000_0400);
    offer_sample(32'h0000_0001, 32'h0000_0410);
    offer_sample(mean_matching_sample(), 32'h0000_0420);  // armed, previous below, sample on mean
    offer_sample(32'h8000_0000, 32'h7FFF_FFFF);
    offer_sample(32'h7FFF_FFFF, 32'h8000_0000);
    offer_sample(32'h5555_5555, 32'hAAAA_AAAA);
    offer_sample(32'hAAAA_AAAA, 32'h5555_5555);
    offer_sample(32'h0000_0000, 32'hFFFF_FFFF);
    offer_sample(32'hFFFF_FFFF, 32'h0000_0000);
    queue_random_samples(250);
    drain();

    // any spread counts, mean never blocks re-arm, no refractory span
    write_register(CFG_SPREAD_THRESHOLD, 64'h0);
    write_register(CFG_REARM_MEAN_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_REFRACTORY_TICKS, 64'h0);
    write_register(CFG_UNUSED_INDEX, {$urandom(), $urandom()});
    queue_random_samples(300);
    drain();

    // no step can be counted and the detector never re-arms
    send_idle_pct = 86;
    recv_idle_pct = 20;
    write_register(CFG_SPREAD_THRESHOLD, 64'hFFFF_FFFF_FFFF_FFFF);
    write_register(CFG_REARM_MEAN_LIMIT, 64'hFFFF_FFFF_0000_0000);
    write_register(CFG_REFRACTORY_TICKS, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_random_samples(150);
    drain();

    // random mid-range settings, full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_register(CFG_SPREAD_THRESHOLD, {$urandom(), $urandom()});
    write_register(CFG_REARM_MEAN_LIMIT, 64'($urandom_range(32'd3500000000, 32'd1500000000)));
    write_register(CFG_REFRACTORY_TICKS, 64'($urandom_range(1000)));
    queue_random_samples(380);
    drain();

    if (error_count == 0 && pending_reports.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
